// File: src/i2cmts_pkg.sv
// Shared types, codes and field layouts for the I2C master transfer sequencer.
package i2cmts_pkg;

    // Default width of the byte counters
    localparam int unsigned COUNT_BITS_DEF = 16;

    // Width of the stream payloads (41 field bits padded to whole bytes)
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned CMD_W     = 3;

    // Request kinds carried on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 3'd0,
        CMD_SENT     = 3'd1,
        CMD_ADDR_ACK = 3'd2,
        CMD_TX_EMPTY = 3'd3,
        CMD_RX_FULL  = 3'd4,
        CMD_BUS_ERR  = 3'd5
    } cmd_t;

    // Transfer phases
    typedef enum logic [2:0] {
        PH_STOPPED    = 3'd0,
        PH_WAIT_START = 3'd1,
        PH_WAIT_ADDR  = 3'd2,
        PH_WAIT_TXE   = 3'd3,
        PH_WAIT_RXNE  = 3'd4,
        PH_HELD       = 3'd5
    } phase_t;

    // ACK control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // Completion status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BUS_ERR = 2'd1;
    localparam logic [1:0] STAT_BUSY    = 2'd2;

    // One input request
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [6:0]       slave_address;
        logic             read_dir;
        logic [15:0]      byte_count;
        logic             stop_at_end;
        logic [7:0]       write_byte;
        logic [7:0]       read_byte;
    } req_t;

    // One result
    typedef struct packed {
        logic        issue_start;
        logic        send_valid;
        logic [7:0]  send_data;
        logic        issue_stop;
        logic [1:0]  ack_control;
        logic        store_valid;
        logic [15:0] store_index;
        logic [7:0]  store_data;
        logic        finished;
        logic [1:0]  status;
    } res_t;

    // Transfer control state (the counters travel separately)
    typedef struct packed {
        phase_t     phase;
        logic [6:0] target_address;
        logic       is_read;
        logic       stop_wanted;
    } ctl_t;

endpackage

// File: src/i2c_master_transfer_sequencer.sv
// Top level of the 7-bit I2C master transfer sequencer.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser = command, s_tdata = transfer fields
//  m_       out  m_tvalid/m_tready  m_tdata = bus actions, store and status fields
//
// One request enters per cycle unless a held result stalls; it passes the input
// register, then the result register, to be valid on m_. Throughput is set
// by the single pass of next-state logic between those registers. Reset clears
// the phase, latched transfer fields and counters. A stalled result holds the
// input register; s_tready stays high while the input register can move on.
module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [6:0] slave_address, [7] read_dir, [23:8] byte_count, [24] stop_at_end,
    // [32:25] write_byte, [40:33] read_byte, [47:41] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] cmd
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] issue_start, [1] send_valid, [9:2] send_data, [10] issue_stop,
    // [12:11] ack_control, [13] store_valid, [29:14] store_index,
    // [37:30] store_data, [38] finished, [40:39] status, [47:41] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    req_t                  req_reg;
    req_t                  req_in;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [COUNT_BITS-1:0] len_reg;
    logic [COUNT_BITS-1:0] len_next;
    logic [COUNT_BITS-1:0] done_reg;
    logic [COUNT_BITS-1:0] done_next;
    res_t                  res;
    res_t                  m_res;
    logic                  stall;
    logic                  adv;
    logic                  s_fire;

    // Unpack the incoming request
    always_comb begin
        req_in.cmd           = s_tuser;
        req_in.slave_address = s_tdata[6:0];
        req_in.read_dir      = s_tdata[7];
        req_in.byte_count    = s_tdata[23:8];
        req_in.stop_at_end   = s_tdata[24];
        req_in.write_byte    = s_tdata[32:25];
        req_in.read_byte     = s_tdata[40:33];
    end

    // Input register handshake
    assign adv      = in_valid_reg && !stall;
    assign s_tready = !in_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= req_in;
        end
    end

    // Transfer state, updated as each request moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase          <= PH_STOPPED;
            ctl_reg.target_address <= '0;
            ctl_reg.is_read        <= 1'b0;
            ctl_reg.stop_wanted    <= 1'b0;
            len_reg                <= '0;
            done_reg               <= '0;
        end else if (adv) begin
            ctl_reg  <= ctl_next;
            len_reg  <= len_next;
            done_reg <= done_next;
        end
    end

    i2cmts_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .req          (req_reg),
        .ctl          (ctl_reg),
        .xfer_len     (len_reg),
        .done_cnt     (done_reg),
        .res          (res),
        .ctl_next     (ctl_next),
        .xfer_len_next(len_next),
        .done_cnt_next(done_next)
    );

    i2cmts_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (adv),
        .res     (res),
        .stall   (stall),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_res   (m_res)
    );

    // Pack the result
    assign m_tdata = {7'd0, m_res.status, m_res.finished, m_res.store_data,
                      m_res.store_index, m_res.store_valid, m_res.ack_control,
                      m_res.issue_stop, m_res.send_data, m_res.send_valid,
                      m_res.issue_start};

    // A finished transfer leaves the bus stopped or held
    a_finish_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res.finished |=> (ctl_reg.phase == PH_STOPPED || ctl_reg.phase == PH_HELD))
        else $error("finished transfer left phase active");

    // While moving data the byte count stays below the length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg.phase == PH_WAIT_TXE || ctl_reg.phase == PH_WAIT_RXNE)
            |-> (done_reg < len_reg))
        else $error("byte count reached length in data phase");

    // A start condition is only requested from an idle bus
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res.issue_start |-> (ctl_reg.phase == PH_STOPPED || ctl_reg.phase == PH_HELD))
        else $error("start requested during a transfer");

endmodule

// File: src/i2cmts_step.sv
// Next-state and result logic for one request of the transfer sequencer.
module i2cmts_step
    import i2cmts_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  req_t                  req,
    input  ctl_t                  ctl,
    input  logic [COUNT_BITS-1:0] xfer_len,
    input  logic [COUNT_BITS-1:0] done_cnt,
    output res_t                  res,
    output ctl_t                  ctl_next,
    output logic [COUNT_BITS-1:0] xfer_len_next,
    output logic [COUNT_BITS-1:0] done_cnt_next
);

    logic [COUNT_BITS+15:0] count_ext;
    logic [COUNT_BITS+15:0] index_ext;
    logic [COUNT_BITS-1:0]  done_inc;
    logic [COUNT_BITS:0]    done_inc2;
    logic [COUNT_BITS-1:0]  tx_done;
    logic                   fin;

    // Counter arithmetic used by the request kinds
    assign count_ext = {{COUNT_BITS{1'b0}}, req.byte_count};
    assign index_ext = {16'd0, done_cnt};
    assign done_inc  = done_cnt + COUNT_BITS'(1);
    assign done_inc2 = {1'b0, done_inc} + (COUNT_BITS+1)'(1);
    assign tx_done   = (done_cnt < xfer_len) ? done_inc : done_cnt;

    always_comb begin
        res           = '0;
        ctl_next      = ctl;
        xfer_len_next = xfer_len;
        done_cnt_next = done_cnt;
        fin           = 1'b0;

        case (req.cmd)
            CMD_START: begin
                if (ctl.phase == PH_STOPPED || ctl.phase == PH_HELD) begin
                    ctl_next.target_address = req.slave_address;
                    ctl_next.is_read        = req.read_dir;
                    ctl_next.stop_wanted    = req.stop_at_end;
                    ctl_next.phase          = PH_WAIT_START;
                    xfer_len_next           = count_ext[COUNT_BITS-1:0];
                    done_cnt_next           = '0;
                    res.issue_start         = 1'b1;
                end else begin
                    res.status = STAT_BUSY;
                end
            end
            CMD_SENT: begin
                if (ctl.phase == PH_WAIT_START) begin
                    res.send_valid = 1'b1;
                    res.send_data  = {ctl.target_address, ctl.is_read};
                    ctl_next.phase = PH_WAIT_ADDR;
                end
            end
            CMD_ADDR_ACK: begin
                if (ctl.phase == PH_WAIT_ADDR) begin
                    if (xfer_len == '0) begin
                        fin = 1'b1;
                    end else if (ctl.is_read) begin
                        res.ack_control = (xfer_len == COUNT_BITS'(1)) ? ACK_NACK : ACK_ACK;
                        ctl_next.phase  = PH_WAIT_RXNE;
                    end else begin
                        // first write byte goes out with the address ack
                        res.send_valid = 1'b1;
                        res.send_data  = req.write_byte;
                        done_cnt_next  = COUNT_BITS'(1);
                        if (xfer_len == COUNT_BITS'(1)) begin
                            fin = 1'b1;
                        end else begin
                            ctl_next.phase = PH_WAIT_TXE;
                        end
                    end
                end
            end
            CMD_TX_EMPTY: begin
                if (ctl.phase == PH_WAIT_TXE) begin
                    if (done_cnt < xfer_len) begin
                        res.send_valid = 1'b1;
                        res.send_data  = req.write_byte;
                    end
                    done_cnt_next = tx_done;
                    fin           = (tx_done >= xfer_len);
                end
            end
            CMD_RX_FULL: begin
                if (ctl.phase == PH_WAIT_RXNE) begin
                    res.store_valid = 1'b1;
                    res.store_index = index_ext[15:0];
                    res.store_data  = req.read_byte;
                    done_cnt_next   = done_inc;
                    // NACK goes with the byte before the last one
                    if (done_inc2 == {1'b0, xfer_len}) begin
                        res.ack_control = ACK_NACK;
                    end else if (done_inc >= xfer_len) begin
                        fin = 1'b1;
                    end
                end
            end
            CMD_BUS_ERR: begin
                if (ctl.phase == PH_HELD) begin
                    res.issue_stop = 1'b1;
                    ctl_next.phase = PH_STOPPED;
                end else if (ctl.phase != PH_STOPPED) begin
                    res.issue_stop = 1'b1;
                    res.finished   = 1'b1;
                    res.status     = STAT_BUS_ERR;
                    ctl_next.phase = PH_STOPPED;
                end
            end
            default: begin
            end
        endcase

        // Normal end of transfer
        if (fin) begin
            res.issue_stop = ctl.stop_wanted;
            res.finished   = 1'b1;
            res.status     = STAT_OK;
            ctl_next.phase = ctl.stop_wanted ? PH_STOPPED : PH_HELD;
        end
    end

endmodule

// File: src/i2cmts_out_reg.sv
// Result register of the sequencer with its stream handshake.
module i2cmts_out_reg
    import i2cmts_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  res_t res,
    output logic stall,
    output logic m_tvalid,
    input  logic m_tready,
    output res_t m_res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // A held result blocks the stage in front of it
    assign stall = valid_reg && !m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule
